// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the DSA signing and verification top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ===== rtl/core/dsa_pkg.sv =====
// Package with the types, codes and constants of the DSA signing and verification block.
package dsa_pkg;

   // Default data width and configuration reset values.
   localparam int DSA_WIDTH   = 32;
   localparam int DSA_P_RESET = 23;
   localparam int DSA_Q_RESET = 11;
   localparam int DSA_G_RESET = 4;
   localparam int DSA_D_RESET = 3;
   localparam int DSA_CSR_W   = 2;

   // Configuration register indexes.
   typedef enum logic [DSA_CSR_W-1:0] {
      CSR_P = 2'd0,
      CSR_Q = 2'd1,
      CSR_G = 2'd2,
      CSR_D = 2'd3
   } csr_index_type;

   // Result status codes.
   typedef enum logic [2:0] {
      ST_VALID    = 3'd0,
      ST_MISMATCH = 3'd1,
      ST_BAD_Q    = 3'd2,
      ST_BAD_G    = 3'd3,
      ST_BAD_D    = 3'd4,
      ST_BAD_K    = 3'd5,
      ST_ZERO_SIG = 3'd6,
      ST_NO_INV   = 3'd7
   } status_type;

   // Operations of the shared multiply and divide unit.
   typedef enum logic {
      ALU_DIV = 1'b0,
      ALU_MUL = 1'b1
   } alu_op_type;

   // Datapath operations.
   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_DIV,
      OP_MUL,
      OP_ADD,
      OP_SUB,
      OP_MOV,
      OP_SHR,
      OP_DEC,
      OP_PINIT,
      OP_IINIT,
      OP_ESTEP,
      OP_TSTEP
   } op_type;

   // Datapath operand and destination registers.
   typedef enum logic [4:0] {
      R_ZERO, R_ONE, R_P, R_Q, R_G, R_D, R_H, R_K, R_HQ, R_Y, R_S1, R_S2, R_W,
      R_U1, R_U2, R_V1, R_V, R_KINV, R_ACC, R_BASE, R_EXP, R_EX, R_EY, R_T1,
      R_T2, R_TMP, R_QT
   } reg_sel_type;

   // Command from the controller to the datapath.
   typedef struct packed {
      op_type      op;
      reg_sel_type a;
      reg_sel_type b;
      reg_sel_type m;
      reg_sel_type dst;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic alu_busy;
      logic alu_done;
      logic a_zero;
      logic a_le_one;
      logic a_eq_one;
      logic a_ge_b;
      logic a_eq_b;
      logic a_lsb;
   } flags_type;

   // Controller states.
   typedef enum logic [5:0] {
      S_IDLE, S_CHK_P, S_CHK_Q, S_PM1, S_PM1_MOD, S_CHK_PM1,
      S_G_RED, S_G_INIT, S_G_CHK, S_D_CHK, S_Y_RED, S_Y_INIT, S_Y_SET,
      S_K_CHK, S_K_INIT, S_K_INV, S_S1_RED, S_S1_INIT, S_S1_MOD,
      S_HQ, S_DS, S_SUM, S_S2, S_Z1, S_Z2, S_W_INIT, S_W_INV, S_U1, S_U2,
      S_V1_RED, S_V1_INIT, S_V1_SET, S_V2_BASE, S_V2_INIT, S_V2_MUL, S_V_MOD,
      S_CMP, S_PW_TEST, S_PW_MUL, S_PW_SQR, S_PW_SHR,
      S_IV_TEST, S_IV_DIV, S_IV_EST, S_IV_QRED, S_IV_MUL, S_IV_SUB, S_IV_TST,
      S_IV_END, S_FIN
   } state_type;

   // Builds a datapath command.
   function automatic cmd_type mk_cmd(op_type op, reg_sel_type a, reg_sel_type b,
                                      reg_sel_type m, reg_sel_type dst);
      cmd_type c;
      c.op  = op;
      c.a   = a;
      c.b   = b;
      c.m   = m;
      c.dst = dst;
      return c;
   endfunction

endpackage

// ===== rtl/core/dsa_if.sv =====
// Valid/ready channel interfaces for the request and response items.
interface dsa_req_if #(parameter int WIDTH = dsa_pkg::DSA_WIDTH);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] message_hash;
   logic [WIDTH-1:0] nonce;

   modport source (output valid, output message_hash, output nonce, input ready);
   modport sink   (input valid, input message_hash, input nonce, output ready);
endinterface

interface dsa_rsp_if #(parameter int WIDTH = dsa_pkg::DSA_WIDTH);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] sig_r;
   logic [WIDTH-1:0] sig_s;
   logic [WIDTH-1:0] public_key;
   logic [WIDTH-1:0] check_value;
   logic [2:0]       status;

   modport source (output valid, output sig_r, output sig_s, output public_key,
                   output check_value, output status, input ready);
   modport sink   (input valid, input sig_r, input sig_s, input public_key,
                   input check_value, input status, output ready);
endinterface

// ===== rtl/core/dsa_alu.sv =====
// Shared iterative unit: restoring division and shift-add modular multiplication.
module dsa_alu #(
   parameter int WIDTH = dsa_pkg::DSA_WIDTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                go,
   input  dsa_pkg::alu_op_type op,
   input  logic [WIDTH-1:0]    a,
   input  logic [WIDTH-1:0]    b,
   input  logic [WIDTH-1:0]    m,
   output logic                busy,
   output logic                done,
   output logic [WIDTH-1:0]    rem,
   output logic [WIDTH-1:0]    quot
);
   import dsa_pkg::*;

   localparam int CW = $clog2(2 * WIDTH);

   logic             busy_ff, busy_in, done_ff, done_in;
   logic [CW-1:0]    cnt_ff, cnt_in, last;
   alu_op_type       op_ff, op_in;
   logic [WIDTH-1:0] a_ff, a_in, m_ff, m_in, r_ff, r_in, x_ff, x_in;
   logic [WIDTH:0]   rem_sh, sum, addend_ext;
   logic [WIDTH-1:0] addend;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Operand and working registers.
   always_ff @(posedge clock) begin
      op_ff <= op_in;
      a_ff  <= a_in;
      m_ff  <= m_in;
      r_ff  <= r_in;
      x_ff  <= x_in;
   end

   // Division takes one quotient bit a cycle; multiplication doubles and then adds per bit.
   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      op_in      = op_ff;
      a_in       = a_ff;
      m_in       = m_ff;
      r_in       = r_ff;
      x_in       = x_ff;
      last       = (op_ff == ALU_DIV) ? CW'(WIDTH - 1) : CW'(2 * WIDTH - 1);
      rem_sh     = {r_ff, x_ff[WIDTH-1]};
      addend     = cnt_ff[0] ? a_ff : r_ff;
      sum        = {1'b0, r_ff} + {1'b0, addend};
      addend_ext = {1'b0, m_ff};
      if (go) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         op_in   = op;
         a_in    = a;
         m_in    = m;
         r_in    = '0;
         x_in    = (op == ALU_DIV) ? a : b;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + CW'(1);
         if (op_ff == ALU_DIV) begin
            if (rem_sh >= addend_ext) begin
               r_in = WIDTH'(rem_sh - addend_ext);
            end else begin
               r_in = rem_sh[WIDTH-1:0];
            end
            x_in = {x_ff[WIDTH-2:0], rem_sh >= addend_ext};
         end else begin
            if (!cnt_ff[0] || x_ff[WIDTH-1]) begin
               r_in = (sum >= addend_ext) ? WIDTH'(sum - addend_ext) : sum[WIDTH-1:0];
            end
            if (cnt_ff[0]) begin
               x_in = {x_ff[WIDTH-2:0], 1'b0};
            end
         end
         if (cnt_ff == last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign rem  = r_ff;
   assign quot = x_ff;

endmodule

// ===== rtl/core/dsa_dp.sv =====
// Datapath: working registers, combinational modular add and subtract, and the shared unit.
module dsa_dp #(
   parameter int WIDTH = dsa_pkg::DSA_WIDTH
) (
   input  logic               clock,
   input  logic               reset,
   input  dsa_pkg::cmd_type   cmd,
   input  logic [WIDTH-1:0]   req_hash,
   input  logic [WIDTH-1:0]   req_nonce,
   input  logic [WIDTH-1:0]   cfg_p,
   input  logic [WIDTH-1:0]   cfg_q,
   input  logic [WIDTH-1:0]   cfg_g,
   input  logic [WIDTH-1:0]   cfg_d,
   output dsa_pkg::flags_type flags,
   output logic [WIDTH-1:0]   sig_r,
   output logic [WIDTH-1:0]   sig_s,
   output logic [WIDTH-1:0]   public_key,
   output logic [WIDTH-1:0]   check_value
);
   import dsa_pkg::*;

   logic [WIDTH-1:0] h_ff, h_in, k_ff, k_in, hq_ff, hq_in, y_ff, y_in;
   logic [WIDTH-1:0] s1_ff, s1_in, s2_ff, s2_in, w_ff, w_in, u1_ff, u1_in;
   logic [WIDTH-1:0] u2_ff, u2_in, v1_ff, v1_in, v_ff, v_in, kinv_ff, kinv_in;
   logic [WIDTH-1:0] acc_ff, acc_in, base_ff, base_in, exp_ff, exp_in;
   logic [WIDTH-1:0] ex_ff, ex_in, ey_ff, ey_in, t1_ff, t1_in, t2_ff, t2_in;
   logic [WIDTH-1:0] tmp_ff, tmp_in, qt_ff, qt_in;
   logic [WIDTH-1:0] a_val, b_val, m_val, wr_data, alu_rem, alu_quot;
   logic [WIDTH:0]   sum, sum_red;
   logic             wr_en, alu_go, alu_busy, alu_done;

   // Operand selection.
   function automatic logic [WIDTH-1:0] rd(reg_sel_type s);
      logic [WIDTH-1:0] r;
      case (s)
         R_ZERO:  r = '0;
         R_ONE:   r = WIDTH'(1);
         R_P:     r = cfg_p;
         R_Q:     r = cfg_q;
         R_G:     r = cfg_g;
         R_D:     r = cfg_d;
         R_H:     r = h_ff;
         R_K:     r = k_ff;
         R_HQ:    r = hq_ff;
         R_Y:     r = y_ff;
         R_S1:    r = s1_ff;
         R_S2:    r = s2_ff;
         R_W:     r = w_ff;
         R_U1:    r = u1_ff;
         R_U2:    r = u2_ff;
         R_V1:    r = v1_ff;
         R_V:     r = v_ff;
         R_KINV:  r = kinv_ff;
         R_ACC:   r = acc_ff;
         R_BASE:  r = base_ff;
         R_EXP:   r = exp_ff;
         R_EX:    r = ex_ff;
         R_EY:    r = ey_ff;
         R_T1:    r = t1_ff;
         R_T2:    r = t2_ff;
         R_TMP:   r = tmp_ff;
         R_QT:    r = qt_ff;
         default: r = '0;
      endcase
      return r;
   endfunction

   assign a_val = rd(cmd.a);
   assign b_val = rd(cmd.b);
   assign m_val = rd(cmd.m);

   // The shared unit starts once per command and reports completion with a pulse.
   assign alu_go = ((cmd.op == OP_DIV) || (cmd.op == OP_MUL)) && !alu_busy && !alu_done;

   dsa_alu #(.WIDTH(WIDTH)) u_alu (
      .clock (clock),
      .reset (reset),
      .go    (alu_go),
      .op    ((cmd.op == OP_MUL) ? ALU_MUL : ALU_DIV),
      .a     (a_val),
      .b     (b_val),
      .m     (m_val),
      .busy  (alu_busy),
      .done  (alu_done),
      .rem   (alu_rem),
      .quot  (alu_quot)
   );

   // Combinational results and the destination write.
   always_comb begin
      sum     = {1'b0, a_val} + {1'b0, b_val};
      sum_red = (sum >= {1'b0, m_val}) ? (sum - {1'b0, m_val}) : sum;
      wr_en   = 1'b0;
      wr_data = a_val;
      case (cmd.op)
         OP_DIV, OP_MUL: begin
            wr_en   = alu_done;
            wr_data = alu_rem;
         end
         OP_ADD: begin
            wr_en   = 1'b1;
            wr_data = sum_red[WIDTH-1:0];
         end
         OP_SUB: begin
            wr_en   = 1'b1;
            wr_data = a_val - b_val + ((a_val >= b_val) ? '0 : m_val);
         end
         OP_MOV: begin
            wr_en   = 1'b1;
            wr_data = a_val;
         end
         OP_SHR: begin
            wr_en   = 1'b1;
            wr_data = a_val >> 1;
         end
         OP_DEC: begin
            wr_en   = 1'b1;
            wr_data = a_val - WIDTH'(1);
         end
         default: begin
            wr_en   = 1'b0;
            wr_data = a_val;
         end
      endcase
   end

   // Next values of the working registers.
   always_comb begin
      h_in = h_ff;  k_in = k_ff;  hq_in = hq_ff;  y_in = y_ff;
      s1_in = s1_ff;  s2_in = s2_ff;  w_in = w_ff;  u1_in = u1_ff;
      u2_in = u2_ff;  v1_in = v1_ff;  v_in = v_ff;  kinv_in = kinv_ff;
      acc_in = acc_ff;  base_in = base_ff;  exp_in = exp_ff;
      ex_in = ex_ff;  ey_in = ey_ff;  t1_in = t1_ff;  t2_in = t2_ff;
      tmp_in = tmp_ff;  qt_in = qt_ff;
      case (cmd.op)
         OP_LOAD: begin
            h_in  = req_hash;
            k_in  = req_nonce;
            y_in  = '0;
            s1_in = '0;
            s2_in = '0;
            v_in  = '0;
         end
         OP_PINIT: begin
            acc_in = WIDTH'(1);
            exp_in = a_val;
         end
         OP_IINIT: begin
            ex_in = m_val;
            ey_in = a_val;
            t1_in = '0;
            t2_in = WIDTH'(1);
         end
         OP_ESTEP: begin
            ex_in = ey_ff;
            ey_in = tmp_ff;
         end
         OP_TSTEP: begin
            t1_in = t2_ff;
            t2_in = tmp_ff;
         end
         OP_DIV: begin
            if (alu_done) begin
               qt_in = alu_quot;
            end
         end
         default: begin
         end
      endcase
      if (wr_en) begin
         case (cmd.dst)
            R_HQ:    hq_in   = wr_data;
            R_Y:     y_in    = wr_data;
            R_S1:    s1_in   = wr_data;
            R_S2:    s2_in   = wr_data;
            R_W:     w_in    = wr_data;
            R_U1:    u1_in   = wr_data;
            R_U2:    u2_in   = wr_data;
            R_V1:    v1_in   = wr_data;
            R_V:     v_in    = wr_data;
            R_KINV:  kinv_in = wr_data;
            R_ACC:   acc_in  = wr_data;
            R_BASE:  base_in = wr_data;
            R_EXP:   exp_in  = wr_data;
            R_EX:    ex_in   = wr_data;
            R_EY:    ey_in   = wr_data;
            R_T1:    t1_in   = wr_data;
            R_T2:    t2_in   = wr_data;
            R_TMP:   tmp_in  = wr_data;
            default: begin
            end
         endcase
      end
   end

   // Working registers hold payload only.
   always_ff @(posedge clock) begin
      h_ff <= h_in;  k_ff <= k_in;  hq_ff <= hq_in;  y_ff <= y_in;
      s1_ff <= s1_in;  s2_ff <= s2_in;  w_ff <= w_in;  u1_ff <= u1_in;
      u2_ff <= u2_in;  v1_ff <= v1_in;  v_ff <= v_in;  kinv_ff <= kinv_in;
      acc_ff <= acc_in;  base_ff <= base_in;  exp_ff <= exp_in;
      ex_ff <= ex_in;  ey_ff <= ey_in;  t1_ff <= t1_in;  t2_ff <= t2_in;
      tmp_ff <= tmp_in;  qt_ff <= qt_in;
   end

   // Status back to the controller.
   always_comb begin
      flags.alu_busy = alu_busy;
      flags.alu_done = alu_done;
      flags.a_zero   = (a_val == '0);
      flags.a_le_one = (a_val <= WIDTH'(1));
      flags.a_eq_one = (a_val == WIDTH'(1));
      flags.a_ge_b   = (a_val >= b_val);
      flags.a_eq_b   = (a_val == b_val);
      flags.a_lsb    = a_val[0];
   end

   assign sig_r       = s1_ff;
   assign sig_s       = s2_ff;
   assign public_key  = y_ff;
   assign check_value = v_ff;

endmodule

// ===== rtl/core/dsa_ctrl.sv =====
// Controller: sequences the checks, exponentiations and inverses of one item.
module dsa_ctrl #(
   parameter int WIDTH = dsa_pkg::DSA_WIDTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               slot_free,
   input  dsa_pkg::flags_type flags,
   output dsa_pkg::cmd_type   cmd,
   output logic               req_ready,
   output logic               emit,
   output logic [2:0]         status
);
   import dsa_pkg::*;

   localparam int CW = $clog2(2 * WIDTH + 5);
   localparam logic [CW-1:0] BOUND = CW'(2 * WIDTH + 4);

   state_type     state_ff, state_in, ret_ff, ret_in;
   status_type    status_ff, status_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          ok_ff, ok_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         ret_ff    <= S_IDLE;
         status_ff <= ST_VALID;
         cnt_ff    <= '0;
         ok_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ret_ff    <= ret_in;
         status_ff <= status_in;
         cnt_ff    <= cnt_in;
         ok_ff     <= ok_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      status_in = status_ff;
      cnt_in    = cnt_ff;
      ok_in     = ok_ff;
      cmd       = mk_cmd(OP_NOP, R_ZERO, R_ZERO, R_ONE, R_ZERO);
      req_ready = 1'b0;
      emit      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd      = mk_cmd(OP_LOAD, R_ZERO, R_ZERO, R_ONE, R_ZERO);
               state_in = S_CHK_P;
            end
         end
         // Domain parameter checks.
         S_CHK_P: begin
            cmd = mk_cmd(OP_NOP, R_P, R_ZERO, R_ONE, R_ZERO);
            if (flags.a_le_one) begin
               status_in = ST_BAD_Q;
               state_in  = S_FIN;
            end else begin
               state_in = S_CHK_Q;
            end
         end
         S_CHK_Q: begin
            cmd = mk_cmd(OP_NOP, R_Q, R_ZERO, R_ONE, R_ZERO);
            if (flags.a_zero) begin
               status_in = ST_BAD_Q;
               state_in  = S_FIN;
            end else begin
               state_in = S_PM1;
            end
         end
         S_PM1: begin
            cmd      = mk_cmd(OP_DEC, R_P, R_ZERO, R_ONE, R_TMP);
            state_in = S_PM1_MOD;
         end
         S_PM1_MOD: begin
            cmd = mk_cmd(OP_DIV, R_TMP, R_ZERO, R_Q, R_TMP);
            if (flags.alu_done) state_in = S_CHK_PM1;
         end
         S_CHK_PM1: begin
            cmd = mk_cmd(OP_NOP, R_TMP, R_ZERO, R_ONE, R_ZERO);
            if (!flags.a_zero) begin
               status_in = ST_BAD_Q;
               state_in  = S_FIN;
            end else begin
               state_in = S_G_RED;
            end
         end
         S_G_RED: begin
            cmd = mk_cmd(OP_DIV, R_G, R_ZERO, R_P, R_BASE);
            if (flags.alu_done) state_in = S_G_INIT;
         end
         S_G_INIT: begin
            cmd      = mk_cmd(OP_PINIT, R_Q, R_ZERO, R_ONE, R_ZERO);
            ret_in   = S_G_CHK;
            state_in = S_PW_TEST;
         end
         S_G_CHK: begin
            cmd = mk_cmd(OP_NOP, R_ACC, R_ZERO, R_ONE, R_ZERO);
            if (!flags.a_eq_one) begin
               status_in = ST_BAD_G;
               state_in  = S_FIN;
            end else begin
               state_in = S_D_CHK;
            end
         end
         S_D_CHK: begin
            cmd = mk_cmd(OP_NOP, R_D, R_Q, R_ONE, R_ZERO);
            if (flags.a_le_one || flags.a_ge_b) begin
               status_in = ST_BAD_D;
               state_in  = S_FIN;
            end else begin
               state_in = S_Y_RED;
            end
         end
         // Public key.
         S_Y_RED: begin
            cmd = mk_cmd(OP_DIV, R_G, R_ZERO, R_P, R_BASE);
            if (flags.alu_done) state_in = S_Y_INIT;
         end
         S_Y_INIT: begin
            cmd      = mk_cmd(OP_PINIT, R_D, R_ZERO, R_ONE, R_ZERO);
            ret_in   = S_Y_SET;
            state_in = S_PW_TEST;
         end
         S_Y_SET: begin
            cmd      = mk_cmd(OP_MOV, R_ACC, R_ZERO, R_ONE, R_Y);
            state_in = S_K_CHK;
         end
         // Nonce check and its inverse.
         S_K_CHK: begin
            cmd = mk_cmd(OP_NOP, R_K, R_Q, R_ONE, R_ZERO);
            if (flags.a_le_one || flags.a_ge_b) begin
               status_in = ST_BAD_K;
               state_in  = S_FIN;
            end else begin
               state_in = S_K_INIT;
            end
         end
         S_K_INIT: begin
            cmd      = mk_cmd(OP_IINIT, R_K, R_ZERO, R_Q, R_ZERO);
            cnt_in   = '0;
            ret_in   = S_K_INV;
            state_in = S_IV_TEST;
         end
         S_K_INV: begin
            cmd = mk_cmd(OP_MOV, R_T1, R_ZERO, R_ONE, R_KINV);
            if (!ok_ff) begin
               status_in = ST_BAD_K;
               state_in  = S_FIN;
            end else begin
               state_in = S_S1_RED;
            end
         end
         // Signature.
         S_S1_RED: begin
            cmd = mk_cmd(OP_DIV, R_G, R_ZERO, R_P, R_BASE);
            if (flags.alu_done) state_in = S_S1_INIT;
         end
         S_S1_INIT: begin
            cmd      = mk_cmd(OP_PINIT, R_K, R_ZERO, R_ONE, R_ZERO);
            ret_in   = S_S1_MOD;
            state_in = S_PW_TEST;
         end
         S_S1_MOD: begin
            cmd = mk_cmd(OP_DIV, R_ACC, R_ZERO, R_Q, R_S1);
            if (flags.alu_done) state_in = S_HQ;
         end
         S_HQ: begin
            cmd = mk_cmd(OP_DIV, R_H, R_ZERO, R_Q, R_HQ);
            if (flags.alu_done) state_in = S_DS;
         end
         S_DS: begin
            cmd = mk_cmd(OP_MUL, R_D, R_S1, R_Q, R_TMP);
            if (flags.alu_done) state_in = S_SUM;
         end
         S_SUM: begin
            cmd      = mk_cmd(OP_ADD, R_HQ, R_TMP, R_Q, R_TMP);
            state_in = S_S2;
         end
         S_S2: begin
            cmd = mk_cmd(OP_MUL, R_KINV, R_TMP, R_Q, R_S2);
            if (flags.alu_done) state_in = S_Z1;
         end
         S_Z1: begin
            cmd = mk_cmd(OP_NOP, R_S1, R_ZERO, R_ONE, R_ZERO);
            if (flags.a_zero) begin
               status_in = ST_ZERO_SIG;
               state_in  = S_FIN;
            end else begin
               state_in = S_Z2;
            end
         end
         S_Z2: begin
            cmd = mk_cmd(OP_NOP, R_S2, R_ZERO, R_ONE, R_ZERO);
            if (flags.a_zero) begin
               status_in = ST_ZERO_SIG;
               state_in  = S_FIN;
            end else begin
               state_in = S_W_INIT;
            end
         end
         // Verification.
         S_W_INIT: begin
            cmd      = mk_cmd(OP_IINIT, R_S2, R_ZERO, R_Q, R_ZERO);
            cnt_in   = '0;
            ret_in   = S_W_INV;
            state_in = S_IV_TEST;
         end
         S_W_INV: begin
            cmd = mk_cmd(OP_MOV, R_T1, R_ZERO, R_ONE, R_W);
            if (!ok_ff) begin
               status_in = ST_NO_INV;
               state_in  = S_FIN;
            end else begin
               state_in = S_U1;
            end
         end
         S_U1: begin
            cmd = mk_cmd(OP_MUL, R_HQ, R_W, R_Q, R_U1);
            if (flags.alu_done) state_in = S_U2;
         end
         S_U2: begin
            cmd = mk_cmd(OP_MUL, R_S1, R_W, R_Q, R_U2);
            if (flags.alu_done) state_in = S_V1_RED;
         end
         S_V1_RED: begin
            cmd = mk_cmd(OP_DIV, R_G, R_ZERO, R_P, R_BASE);
            if (flags.alu_done) state_in = S_V1_INIT;
         end
         S_V1_INIT: begin
            cmd      = mk_cmd(OP_PINIT, R_U1, R_ZERO, R_ONE, R_ZERO);
            ret_in   = S_V1_SET;
            state_in = S_PW_TEST;
         end
         S_V1_SET: begin
            cmd      = mk_cmd(OP_MOV, R_ACC, R_ZERO, R_ONE, R_V1);
            state_in = S_V2_BASE;
         end
         S_V2_BASE: begin
            cmd      = mk_cmd(OP_MOV, R_Y, R_ZERO, R_ONE, R_BASE);
            state_in = S_V2_INIT;
         end
         S_V2_INIT: begin
            cmd      = mk_cmd(OP_PINIT, R_U2, R_ZERO, R_ONE, R_ZERO);
            ret_in   = S_V2_MUL;
            state_in = S_PW_TEST;
         end
         S_V2_MUL: begin
            cmd = mk_cmd(OP_MUL, R_V1, R_ACC, R_P, R_TMP);
            if (flags.alu_done) state_in = S_V_MOD;
         end
         S_V_MOD: begin
            cmd = mk_cmd(OP_DIV, R_TMP, R_ZERO, R_Q, R_V);
            if (flags.alu_done) state_in = S_CMP;
         end
         S_CMP: begin
            cmd       = mk_cmd(OP_NOP, R_V, R_S1, R_ONE, R_ZERO);
            status_in = flags.a_eq_b ? ST_VALID : ST_MISMATCH;
            state_in  = S_FIN;
         end
         // Square-and-multiply modulo p, exponent taken from the low bit up.
         S_PW_TEST: begin
            cmd = mk_cmd(OP_NOP, R_EXP, R_ZERO, R_ONE, R_ZERO);
            if (flags.a_zero) begin
               state_in = ret_ff;
            end else if (flags.a_lsb) begin
               state_in = S_PW_MUL;
            end else begin
               state_in = S_PW_SQR;
            end
         end
         S_PW_MUL: begin
            cmd = mk_cmd(OP_MUL, R_ACC, R_BASE, R_P, R_ACC);
            if (flags.alu_done) state_in = S_PW_SQR;
         end
         S_PW_SQR: begin
            cmd = mk_cmd(OP_MUL, R_BASE, R_BASE, R_P, R_BASE);
            if (flags.alu_done) state_in = S_PW_SHR;
         end
         S_PW_SHR: begin
            cmd      = mk_cmd(OP_SHR, R_EXP, R_ZERO, R_ONE, R_EXP);
            state_in = S_PW_TEST;
         end
         // Extended Euclid modulo q with a bounded number of steps.
         S_IV_TEST: begin
            cmd = mk_cmd(OP_NOP, R_EY, R_ZERO, R_ONE, R_ZERO);
            if (flags.a_zero || (cnt_ff == BOUND)) begin
               state_in = S_IV_END;
            end else begin
               state_in = S_IV_DIV;
            end
         end
         S_IV_DIV: begin
            cmd = mk_cmd(OP_DIV, R_EX, R_ZERO, R_EY, R_TMP);
            if (flags.alu_done) state_in = S_IV_EST;
         end
         S_IV_EST: begin
            cmd      = mk_cmd(OP_ESTEP, R_ZERO, R_ZERO, R_ONE, R_ZERO);
            state_in = S_IV_QRED;
         end
         S_IV_QRED: begin
            cmd = mk_cmd(OP_DIV, R_QT, R_ZERO, R_Q, R_TMP);
            if (flags.alu_done) state_in = S_IV_MUL;
         end
         S_IV_MUL: begin
            cmd = mk_cmd(OP_MUL, R_TMP, R_T2, R_Q, R_TMP);
            if (flags.alu_done) state_in = S_IV_SUB;
         end
         S_IV_SUB: begin
            cmd      = mk_cmd(OP_SUB, R_T1, R_TMP, R_Q, R_TMP);
            state_in = S_IV_TST;
         end
         S_IV_TST: begin
            cmd      = mk_cmd(OP_TSTEP, R_ZERO, R_ZERO, R_ONE, R_ZERO);
            cnt_in   = cnt_ff + CW'(1);
            state_in = S_IV_TEST;
         end
         S_IV_END: begin
            cmd      = mk_cmd(OP_NOP, R_EX, R_ZERO, R_ONE, R_ZERO);
            ok_in    = flags.a_eq_one;
            state_in = ret_ff;
         end
         // Hand the result to the output register once it is free.
         S_FIN: begin
            if (slot_free) begin
               emit     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign status = status_ff;

endmodule

// ===== rtl/core/dsa_sign_and_verify.sv =====
// Top level of the DSA signing and verification block.
//
//   channel   direction  handshake          content
//   req_if    in         valid/ready        message_hash, nonce
//   rsp_if    out        valid/ready        sig_r, sig_s, public_key, check_value, status
//   csr_*     in         write enable only  index and data of p, q, g, d
//
// One shared unit does every product and every reduction. Five exponentiations work through
// the exponent bit by bit, and two inverses take a bounded number of Euclid steps.
// A bad p or q ends within one division, a bad g after one power.
// Synchronous active-high reset returns the controller to idle and loads the register
// reset values. A result waits in the output register while the next item is taken.
`include "assert_macros.svh"

module dsa_sign_and_verify #(
   parameter int WIDTH = dsa_pkg::DSA_WIDTH
) (
   input  logic                         clock,
   input  logic                         reset,
   dsa_req_if.sink                      req_if,
   dsa_rsp_if.source                    rsp_if,
   input  logic                         csr_we,
   input  logic [dsa_pkg::DSA_CSR_W-1:0] csr_index,
   input  logic [WIDTH-1:0]             csr_wdata
);
   import dsa_pkg::*;

   logic [WIDTH-1:0] p_ff, q_ff, g_ff, d_ff;
   logic [WIDTH-1:0] sig_r, sig_s, public_key, check_value;
   logic [WIDTH-1:0] r_ff, s_ff, y_ff, v_ff;
   logic [2:0]       status, st_ff;
   logic             rsp_valid_ff, slot_free, emit, req_ready;
   cmd_type          cmd;
   flags_type        flags;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         p_ff <= WIDTH'(DSA_P_RESET);
         q_ff <= WIDTH'(DSA_Q_RESET);
         g_ff <= WIDTH'(DSA_G_RESET);
         d_ff <= WIDTH'(DSA_D_RESET);
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_P:   p_ff <= csr_wdata;
            CSR_Q:   q_ff <= csr_wdata;
            CSR_G:   g_ff <= csr_wdata;
            CSR_D:   d_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   dsa_ctrl #(.WIDTH(WIDTH)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .slot_free (slot_free),
      .flags     (flags),
      .cmd       (cmd),
      .req_ready (req_ready),
      .emit      (emit),
      .status    (status)
   );

   dsa_dp #(.WIDTH(WIDTH)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_hash    (req_if.message_hash),
      .req_nonce   (req_if.nonce),
      .cfg_p       (p_ff),
      .cfg_q       (q_ff),
      .cfg_g       (g_ff),
      .cfg_d       (d_ff),
      .flags       (flags),
      .sig_r       (sig_r),
      .sig_s       (sig_s),
      .public_key  (public_key),
      .check_value (check_value)
   );

   assign req_if.ready = req_ready;

   // Output register: holds one finished item until the sink takes it.
   assign slot_free = !rsp_valid_ff || rsp_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         r_ff  <= sig_r;
         s_ff  <= sig_s;
         y_ff  <= public_key;
         v_ff  <= check_value;
         st_ff <= status;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.sig_r       = r_ff;
   assign rsp_if.sig_s       = s_ff;
   assign rsp_if.public_key  = y_ff;
   assign rsp_if.check_value = v_ff;
   assign rsp_if.status      = st_ff;

   // A result is only handed over when the output register can take it.
   `ASSERT_IMPLIES(a_emit_into_free_slot, clock, reset, emit, !rsp_valid_ff || rsp_if.ready)
   // The shared unit only reports completion after it has been busy.
   `ASSERT_IMPLIES(a_done_follows_busy, clock, reset, flags.alu_done, $past(flags.alu_busy))
   // One item is worked on at a time.
   `ASSERT_NEXT(a_one_item_in_flight, clock, reset, req_if.valid && req_if.ready, !req_if.ready)

endmodule

// ===== sim/tb_dsa_sign_and_verify.sv =====
// Self-checking testbench of the DSA signing and verification block.
`timescale 1ns / 100ps

module tb_dsa_sign_and_verify;
   import dsa_pkg::*;

   localparam int W          = DSA_WIDTH;
   localparam int STALL_LIMIT = 400000;

   typedef logic [W-1:0] word_t;
   typedef longint unsigned u64_t;

   // One result item as the block should return it.
   typedef struct {
      word_t      sig_r;
      word_t      sig_s;
      word_t      public_key;
      word_t      check_value;
      status_type status;
   } signature_t;

   // One row of the directed table.
   typedef struct {
      word_t      hash;
      word_t      nonce;
      bit         typed;
      signature_t want;
   } directed_row_t;

   // One setting of the domain parameters and key for a random phase.
   typedef struct {
      word_t p;
      word_t q;
      word_t g;
      word_t d;
      int    items;
   } domain_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [DSA_CSR_W-1:0] csr_index = '0;
   word_t csr_wdata = '0;

   dsa_req_if #(.WIDTH(W)) req ();
   dsa_rsp_if #(.WIDTH(W)) rsp ();

   dsa_sign_and_verify #(.WIDTH(W)) dut (
      .clock(clock), .reset(reset), .req_if(req), .rsp_if(rsp),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Local copy of the configuration registers.
   word_t cfg_p = DSA_P_RESET;
   word_t cfg_q = DSA_Q_RESET;
   word_t cfg_g = DSA_G_RESET;
   word_t cfg_d = DSA_D_RESET;

   signature_t pending_sigs[$];
   int  mismatches = 0;
   int  results_seen = 0;
   int  items_sent = 0;
   int  items_total = 0;
   int  stall_cycles = 0;
   bit  idling_on = 1'b1;
   int  ready_burst = 0;

   always #10 clock = ~clock;

   // Modular arithmetic on operands below 2^32, so every product fits in 64 bits.
   function automatic u64_t mulm(u64_t a, u64_t b, u64_t m);
      return ((a % m) * (b % m)) % m;
   endfunction

   function automatic u64_t powm(u64_t b, u64_t e, u64_t m);
      u64_t r;
      r = 1 % m;
      b = b % m;
      while (e > 0) begin
         if (e[0]) r = mulm(r, b, m);
         b = mulm(b, b, m);
         e = e >> 1;
      end
      return r;
   endfunction

   // Extended Euclid, bounded; returns 1 when a is invertible modulo m.
   function automatic bit invm(u64_t a, u64_t m, output u64_t inv);
      u64_t x, y, t1, t2, qt, rem, prod, nt;
      x = m; y = a; t1 = 0; t2 = 1;
      for (int n = 0; n < 2 * W + 4 && y != 0; n++) begin
         qt = x / y;
         rem = x % y;
         x = y;
         y = rem;
         prod = mulm(qt, t2, m);
         nt = (t1 >= prod) ? t1 - prod : t1 + (m - prod);
         t1 = t2;
         t2 = nt;
      end
      inv = t1 % m;
      return x == 1;
   endfunction

   // Signs h with nonce k under the current registers and verifies the signature.
   function automatic signature_t sign_and_check(word_t hash, word_t nonce);
      signature_t s;
      u64_t p, q, g, d, h, k, kinv, w, u1, u2, v1, v2;
      p = u64_t'(cfg_p); q = u64_t'(cfg_q); g = u64_t'(cfg_g); d = u64_t'(cfg_d);
      h = u64_t'(hash); k = u64_t'(nonce);
      s.sig_r = '0; s.sig_s = '0; s.public_key = '0; s.check_value = '0;
      if (p < 2 || q == 0 || ((p - 1) % q) != 0) begin
         s.status = ST_BAD_Q;
      end else if (powm(g, q, p) != 1) begin
         s.status = ST_BAD_G;
      end else if (d <= 1 || d >= q) begin
         s.status = ST_BAD_D;
      end else begin
         s.public_key = word_t'(powm(g, d, p));
         if (k <= 1 || k >= q || !invm(k, q, kinv)) begin
            s.status = ST_BAD_K;
         end else begin
            s.sig_r = word_t'(powm(g, k, p) % q);
            s.sig_s = word_t'(mulm(kinv, (h % q + mulm(d, u64_t'(s.sig_r), q)) % q, q));
            if (s.sig_r == 0 || s.sig_s == 0) begin
               s.status = ST_ZERO_SIG;
            end else if (!invm(u64_t'(s.sig_s), q, w)) begin
               s.status = ST_NO_INV;
            end else begin
               u1 = mulm(h, w, q);
               u2 = mulm(u64_t'(s.sig_r), w, q);
               v1 = powm(g, u1, p);
               v2 = powm(u64_t'(s.public_key), u2, p);
               s.check_value = word_t'(mulm(v1, v2, p) % q);
               s.status = (s.check_value == s.sig_r) ? ST_VALID : ST_MISMATCH;
            end
         end
      end
      return s;
   endfunction

   // Offers one item, with an optional gap before it, and records what it should give.
   task automatic send_item(word_t hash, word_t nonce, bit typed, signature_t want);
      int gap;
      gap = (idling_on && $urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req.valid <= 1'b1;
      req.message_hash <= hash;
      req.nonce <= nonce;
      do @(posedge clock); while (!req.ready);
      pending_sigs.push_back(typed ? want : sign_and_check(hash, nonce));
      items_sent++;
      idling_on = items_sent < (items_total * 85) / 100;
   endtask

   // Waits until every result is in, then lets the block settle.
   task automatic drain();
      @(negedge clock);
      req.valid <= 1'b0;
      while (pending_sigs.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Writes all four registers on consecutive cycles.
   task automatic load_domain(domain_t dom);
      word_t vals[4];
      vals = '{dom.p, dom.q, dom.g, dom.d};
      for (int i = 0; i < 4; i++) begin
         @(negedge clock);
         csr_we <= 1'b1;
         csr_index <= DSA_CSR_W'(i);
         csr_wdata <= vals[i];
      end
      @(negedge clock);
      csr_we <= 1'b0;
      cfg_p = dom.p; cfg_q = dom.q; cfg_g = dom.g; cfg_d = dom.d;
   endtask

   // Response side: random stall bursts while idling is on, otherwise always ready.
   always @(negedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
         ready_burst <= 0;
      end else if (!idling_on) begin
         rsp.ready <= 1'b1;
      end else if (ready_burst > 0) begin
         ready_burst <= ready_burst - 1;
      end else begin
         rsp.ready <= ~rsp.ready;
         ready_burst <= $urandom_range(0, 5);
      end
   end

   // Result check and watchdog.
   always @(posedge clock) begin
      signature_t exp_sig;
      if (!reset) begin
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            stall_cycles <= 0;
         else
            stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no item moved for %0d cycles", STALL_LIMIT);
            $display("dsa_sign_and_verify test failed");
            $finish;
         end
         if (rsp.valid && rsp.ready) begin
            results_seen++;
            if (pending_sigs.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("Unexpected result item at %0t", $realtime);
            end else begin
               exp_sig = pending_sigs.pop_front();
               if (rsp.sig_r !== exp_sig.sig_r || rsp.sig_s !== exp_sig.sig_s ||
                   rsp.public_key !== exp_sig.public_key ||
                   rsp.check_value !== exp_sig.check_value ||
                   rsp.status !== exp_sig.status) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("Mismatch at %0t: exp r=%h s=%h y=%h v=%h st=%s, got r=%h s=%h y=%h v=%h st=%0d",
                              $realtime, exp_sig.sig_r, exp_sig.sig_s, exp_sig.public_key,
                              exp_sig.check_value, exp_sig.status.name(), rsp.sig_r,
                              rsp.sig_s, rsp.public_key, rsp.check_value, rsp.status);
               end
            end
         end
      end
   end

   initial begin
      directed_row_t rows[$];
      domain_t phases[$];
      signature_t none;
      word_t h, k, big_p;
      req.valid = 1'b0;
      req.message_hash = '0;
      req.nonce = '0;
      none = '{default: '0, status: ST_VALID};

      // Directed rows under the reset values: y is 4^3 mod 23 = 18.
      rows.push_back('{32'h0, 32'h0, 1'b1, '{0, 0, 18, 0, ST_BAD_K}});
      rows.push_back('{32'hFFFF_FFFF, 32'h1, 1'b1, '{0, 0, 18, 0, ST_BAD_K}});
      rows.push_back('{32'h1234_5678, 32'd11, 1'b1, '{0, 0, 18, 0, ST_BAD_K}});
      rows.push_back('{32'h0, 32'hFFFF_FFFF, 1'b1, '{0, 0, 18, 0, ST_BAD_K}});
      for (int i = 2; i <= 10; i++)
         rows.push_back('{(i % 2) ? 32'hFFFF_FFFF : 32'(i * 7), 32'(i), 1'b0, none});
      rows.push_back('{32'hAAAA_AAAA, 32'd5, 1'b0, none});
      rows.push_back('{32'h5555_5555, 32'd5, 1'b0, none});

      // Random phases: valid groups, a composite order, and broken parameter sets.
      big_p = 32'd2147483647;
      phases.push_back('{big_p, 331, word_t'(powm(7, (big_p - 1) / 331, big_p)),
                         $urandom_range(2, 330), 30});
      phases.push_back('{13, 6, 4, 5, 20});
      phases.push_back('{47, 23, 25, 7, 25});
      phases.push_back('{0, 0, 0, 0, 5});
      phases.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5});
      phases.push_back('{1, 1, 1, 1, 5});
      phases.push_back('{23, 11, 5, 3, 5});
      phases.push_back('{23, 11, 4, 11, 5});

      items_total = rows.size();
      foreach (phases[i]) items_total += phases[i].items;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (rows[i]) send_item(rows[i].hash, rows[i].nonce, rows[i].typed, rows[i].want);
      drain();

      foreach (phases[i]) begin
         load_domain(phases[i]);
         for (int n = 0; n < phases[i].items; n++) begin
            h = $urandom();
            if ($urandom_range(0, 4) == 0 || cfg_q == 32'hFFFF_FFFF)
               k = $urandom();
            else
               k = $urandom_range(0, cfg_q);
            send_item(h, k, 1'b0, none);
         end
         drain();
      end

      $display("Covered %0d items across %0d register settings, %0d results checked.",
               items_sent, phases.size() + 1, results_seen);
      if (mismatches == 0 && pending_sigs.size() == 0)
         $display("dsa_sign_and_verify test passed");
      else
         $display("dsa_sign_and_verify test failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/dsa_pkg.sv
rtl/core/dsa_if.sv
rtl/core/dsa_alu.sv
rtl/core/dsa_dp.sv
rtl/core/dsa_ctrl.sv
rtl/core/dsa_sign_and_verify.sv
sim/tb_dsa_sign_and_verify.sv
